// ===== rtl/wat_pkg.sv =====
// ============================================================================
// Window average and trend: shared definitions
// Field widths, reset values and the request/status bundles of the divider.
// ============================================================================
`default_nettype none

package wat_pkg;

    // Fixed field widths.
    localparam int CNT_W    = 7;
    localparam int SAMPLE_W = 32;

    // Default ring depth and the reset value of window_length.
    localparam int            MAX_WINDOW_DEF = 64;
    localparam logic [CNT_W-1:0] WL_RESET     = 7'd50;

    // Saturation limits of a signed Q16.16 result.
    localparam logic [SAMPLE_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [SAMPLE_W-1:0] SAT_MIN = 32'h8000_0000;

    // Request to the shared divider. A short operation runs only on the
    // upper part of the dividend.
    typedef struct packed {
        logic start;
        logic short_op;
    } div_req_t;

    // Divider status. The done flag is high for one cycle.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/wat_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ============================================================================
`default_nettype none

module wat_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/wat_div.sv =====
// ============================================================================
// Shared unsigned divider
// Restoring division, two quotient bits per cycle, MSB of the dividend first.
// ============================================================================
`default_nettype none

module wat_div #(
    parameter int DVD_W   = 58,
    parameter int DVS_W   = 28,
    parameter int SHORT_W = 38
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire wat_pkg::div_req_t     req,
    input  wire logic [DVD_W-1:0]      dividend,
    input  wire logic [DVS_W-1:0]      divisor,
    output wat_pkg::div_stat_t         stat,
    output logic      [DVD_W-1:0]      quotient
);
    import wat_pkg::*;

    localparam int STEPS_LONG  = DVD_W / 2;
    localparam int STEPS_SHORT = SHORT_W / 2;
    localparam int STEP_W      = $clog2(STEPS_LONG + 1);

    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W-1:0]  r_reg;
    logic [DVS_W-1:0]  d_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DVS_W:0]    r1, r2;
    logic              ge1, ge2;
    logic [DVS_W-1:0]  r1_rem, r2_rem;
    logic [DVD_W-1:0]  q1, q2;

    // Two restoring steps per cycle.
    always_comb begin
        r1     = {r_reg, q_reg[DVD_W-1]};
        ge1    = r1 >= {1'b0, d_reg};
        r1_rem = ge1 ? DVS_W'(r1 - {1'b0, d_reg}) : DVS_W'(r1);
        q1     = {q_reg[DVD_W-2:0], ge1};
        r2     = {r1_rem, q1[DVD_W-1]};
        ge2    = r2 >= {1'b0, d_reg};
        r2_rem = ge2 ? DVS_W'(r2 - {1'b0, d_reg}) : DVS_W'(r2);
        q2     = {q1[DVD_W-2:0], ge2};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                step_reg <= req.short_op ? STEP_W'(STEPS_SHORT) : STEP_W'(STEPS_LONG);
            end else if (busy_reg) begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= q2;
            r_reg <= r2_rem;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

`default_nettype wire

// ===== rtl/window_average_and_trend_core.sv =====
// ============================================================================
// Window average and trend core
// Throughput: one transaction at a time; the next input is taken when the
// sequencer is back in idle, which the mean division and, with two or
// more samples held, the slope division on the shared radix-4 divider set,
// along with any stall on the result side. Reset (aresetn, synchronous)
// empties the window and loads window_length with 50; the sample ring needs
// no clearing pass.
// ============================================================================
`default_nettype none

module window_average_and_trend_core #(
    parameter int MAX_WINDOW = wat_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration: window_length.
    input  wire logic                               cfg_wr_en,
    input  wire logic        [wat_pkg::CNT_W-1:0]   cfg_wr_data,
    // Input samples.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [wat_pkg::SAMPLE_W-1:0] s_fitness_sample,
    // Results.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic             [wat_pkg::CNT_W-1:0]   m_samples_held,
    output logic signed      [wat_pkg::SAMPLE_W-1:0] m_window_mean,
    output logic signed      [wat_pkg::SAMPLE_W-1:0] m_trend_slope
);
    import wat_pkg::*;

    // ------------------------------------------------------------------
    // Derived widths. The window can never hold more than the largest
    // window_length value, so the sample count stays CNT_W bits wide.
    // ------------------------------------------------------------------
    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MAX_CNT = (MAX_WINDOW > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1
                                                             : MAX_WINDOW;
    localparam int CMP_W   = (IDX_W + 1 > CNT_W) ? IDX_W + 1 : CNT_W;
    localparam int SUM_W   = SAMPLE_W + IDX_W;
    localparam int WSUM_W  = SAMPLE_W + 1 + 2 * IDX_W;
    localparam int SX_W    = 2 * CNT_W;
    localparam int NY_W    = CNT_W + 1 + SAMPLE_W;
    localparam int PA_W    = CNT_W + 1 + WSUM_W;
    localparam int PB_W    = SX_W + 1 + SUM_W;
    localparam int NUM_W   = ((PA_W > PB_W) ? PA_W : PB_W) + 1;
    localparam int DVD_W   = ((NUM_W + 4 + 1) / 2) * 2;
    localparam int DVS_W   = 4 * CNT_W;
    localparam int MEAN_W  = ((SUM_W + 1) / 2) * 2;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_SHIFT = 4'd2;
    localparam logic [3:0] ST_PROD  = 4'd3;
    localparam logic [3:0] ST_ACC   = 4'd4;
    localparam logic [3:0] ST_MUL   = 4'd5;
    localparam logic [3:0] ST_MEAN  = 4'd6;
    localparam logic [3:0] ST_SLOPE = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    logic [3:0]               state_reg, state_next;
    logic [CNT_W-1:0]         wl_reg;
    logic [CNT_W-1:0]         held_cnt_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [WSUM_W-1:0] wsum_reg;
    logic                     m_valid_reg;

    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [NY_W-1:0]   ny_reg;
    logic [SX_W-1:0]          sx_reg;
    logic [SX_W-1:0]          nsq_reg;
    logic signed [PA_W-1:0]   pa_reg;
    logic signed [PB_W-1:0]   pb_reg;
    logic [DVS_W-1:0]         den_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]         nabs_reg;
    logic                     num_neg_reg;
    logic [DVD_W-1:0]         dvd12_reg;
    logic                     mean_neg_reg;
    logic [SAMPLE_W-1:0]      mean_reg;
    logic [SAMPLE_W-1:0]      slope_reg;
    logic [CNT_W-1:0]         m_held_reg;
    logic [SAMPLE_W-1:0]      m_mean_reg;
    logic [SAMPLE_W-1:0]      m_slope_reg;

    // ------------------------------------------------------------------
    // Window bookkeeping.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  eff_len;
    logic              full;
    logic [CNT_W-1:0]  nm1;
    logic [CMP_W-1:0]  slot_inc;
    logic              slot_wrap;
    logic              accept;

    // A length of zero acts as one; anything beyond the ring acts as its depth.
    always_comb begin
        if (wl_reg == '0) begin
            eff_len = CNT_W'(1);
        end else if (wl_reg > CNT_W'(MAX_CNT)) begin
            eff_len = CNT_W'(MAX_CNT);
        end else begin
            eff_len = wl_reg;
        end
    end

    assign full      = held_cnt_reg >= eff_len;
    assign nm1       = held_cnt_reg - CNT_W'(1);
    assign slot_inc  = CMP_W'(slot_reg) + CMP_W'(1);
    assign slot_wrap = slot_inc >= CMP_W'(eff_len);
    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Sample ring. While the window fills, the new sample goes to the slot
    // named by the count. Once it is full, the oldest slot is read on
    // acceptance and overwritten with the new sample in the following cycle, so
    // a read and a write never meet on the same entry in the same cycle.
    // ------------------------------------------------------------------
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [SAMPLE_W-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [SAMPLE_W-1:0] ram_rd_data;

    assign ram_rd_en   = accept && full;
    assign ram_wr_en   = (accept && !full) || (state_reg == ST_READ);
    assign ram_wr_addr = (state_reg == ST_READ) ? slot_reg : IDX_W'(held_cnt_reg);
    assign ram_wr_data = (state_reg == ST_READ) ? y_reg : s_fitness_sample;

    wat_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (slot_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared divider. The mean divides the sum magnitude by the count; the
    // slope divides 12 * |num| by n^2 * (n^2 - 1), which is twelve times the
    // textbook denominator, so the truncated quotient is unchanged.
    // The sum is placed at the top of the dividend so that the short
    // operation only walks its own bits.
    // ------------------------------------------------------------------
    div_req_t          div_req;
    div_stat_t         div_stat;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DVD_W-1:0]  div_quot;
    logic [SUM_W-1:0]  sum_abs;
    logic              more_than_one;

    assign more_than_one = held_cnt_reg >= CNT_W'(2);
    assign sum_abs       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);

    assign div_req.start    = (state_reg == ST_MUL) ||
                              ((state_reg == ST_MEAN) && div_stat.done && more_than_one);
    assign div_req.short_op = (state_reg == ST_MUL);
    assign div_dividend     = (state_reg == ST_MUL)
                            ? (DVD_W'(sum_abs) << (DVD_W - MEAN_W)) : dvd12_reg;
    assign div_divisor      = (state_reg == ST_MUL) ? DVS_W'(held_cnt_reg) : den_reg;

    wat_div #(
        .DVD_W   (DVD_W),
        .DVS_W   (DVS_W),
        .SHORT_W (MEAN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // Signed saturation of the divider's quotient magnitude to Q16.16.
    logic                quot_neg;
    logic                quot_hi;
    logic                over_pos;
    logic                over_neg;
    logic [SAMPLE_W-1:0] quot_sat;

    always_comb begin
        quot_neg = (state_reg == ST_MEAN) ? mean_neg_reg : num_neg_reg;
        quot_hi  = |div_quot[DVD_W-1:SAMPLE_W];
        over_pos = quot_hi || div_quot[SAMPLE_W-1];
        over_neg = quot_hi || (div_quot[SAMPLE_W-1] && (|div_quot[SAMPLE_W-2:0]));
        if (quot_neg) begin
            quot_sat = over_neg ? SAT_MIN : SAMPLE_W'(-div_quot[SAMPLE_W-1:0]);
        end else begin
            quot_sat = over_pos ? SAT_MAX : div_quot[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = full ? ST_READ : ST_PROD;
                end
            end
            ST_READ:  state_next = ST_SHIFT;
            ST_SHIFT: state_next = ST_PROD;
            ST_PROD:  state_next = ST_ACC;
            ST_ACC:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_MEAN;
            ST_MEAN: begin
                if (div_stat.done) begin
                    state_next = more_than_one ? ST_SLOPE : ST_OUT;
                end
            end
            ST_SLOPE: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state and running sums. A configuration write is to arrive only
    // while the core is idle (not enforced here); it empties the window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wl_reg       <= WL_RESET;
            held_cnt_reg <= '0;
            slot_reg     <= '0;
            sum_reg      <= '0;
            wsum_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                wl_reg       <= cfg_wr_data;
                held_cnt_reg <= '0;
                slot_reg     <= '0;
                sum_reg      <= '0;
                wsum_reg     <= '0;
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        if (accept && !full) begin
                            held_cnt_reg <= held_cnt_reg + CNT_W'(1);
                        end
                    end
                    ST_READ: begin
                        // Drop the oldest sample and advance the ring.
                        sum_reg  <= sum_reg - SUM_W'($signed(ram_rd_data));
                        slot_reg <= slot_wrap ? '0 : IDX_W'(slot_inc);
                    end
                    ST_SHIFT: begin
                        // Every remaining sample moves down one index.
                        wsum_reg <= wsum_reg - WSUM_W'(sum_reg);
                    end
                    ST_ACC: begin
                        sum_reg  <= sum_reg + SUM_W'(y_reg);
                        wsum_reg <= wsum_reg + WSUM_W'(ny_reg);
                    end
                    default: begin
                    end
                endcase
            end

            if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers; the products are formed in the PROD and MUL states and registered.
    always_ff @(posedge aclk) begin
        if (accept) begin
            y_reg <= s_fitness_sample;
        end
        if (state_reg == ST_PROD) begin
            ny_reg  <= $signed({1'b0, nm1}) * y_reg;
            sx_reg  <= (SX_W'(held_cnt_reg) * SX_W'(nm1)) >> 1;
            nsq_reg <= held_cnt_reg * held_cnt_reg;
        end
        if (state_reg == ST_MUL) begin
            pa_reg       <= $signed({1'b0, held_cnt_reg}) * wsum_reg;
            pb_reg       <= $signed({1'b0, sx_reg}) * sum_reg;
            den_reg      <= nsq_reg * (nsq_reg - SX_W'(1));
            mean_neg_reg <= sum_reg[SUM_W-1];
        end
        // The slope dividend settles while the mean division runs.
        num_reg     <= NUM_W'(pa_reg) - NUM_W'(pb_reg);
        num_neg_reg <= num_reg[NUM_W-1];
        nabs_reg    <= num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
        dvd12_reg   <= (DVD_W'(nabs_reg) << 3) + (DVD_W'(nabs_reg) << 2);

        if (state_reg == ST_MEAN && div_stat.done) begin
            mean_reg  <= quot_sat;
            slope_reg <= '0;
        end
        if (state_reg == ST_SLOPE && div_stat.done) begin
            slope_reg <= quot_sat;
        end
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_held_reg  <= held_cnt_reg;
            m_mean_reg  <= mean_reg;
            m_slope_reg <= slope_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_samples_held = m_held_reg;
    assign m_window_mean  = $signed(m_mean_reg);
    assign m_trend_slope  = $signed(m_slope_reg);

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_held_within_length: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg <= eff_len)
        else $error("sample count exceeds the window length");

    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(slot_reg) < CMP_W'(eff_len))
        else $error("oldest slot lies outside the window");

    a_slot_zero_while_filling: assert property (@(posedge aclk) disable iff (!aresetn)
        !full |-> slot_reg == '0)
        else $error("oldest slot moved before the window filled");

    a_ring_read_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |=> state_reg == ST_READ)
        else $error("ring read not followed by the replace step");

    a_div_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_stat.busy)
        else $error("divider started while busy");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_window_average_and_trend_core.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Testbench: window average and trend core
// Feeds signed Q16.16 fitness samples through the valid/ready input channel,
// predicts the window count, mean and least-squares slope of every sample
// from running sums kept here, and checks each result transaction against
// the oldest prediction. The window length is rewritten between phases,
// including the zero and oversized settings.
// ============================================================================

module tb_window_average_and_trend_core;
    import wat_pkg::*;

    // Cycle limit for the whole run.
    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned SAMPLE_COUNT = 1950;

    // One predicted result transaction.
    typedef struct {
        logic        [CNT_W-1:0]    held;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] slope;
    } trend_result_t;

    // Keeps its own copy of the window, the running sums and the window
    // length, and lines up the predicted result of each accepted sample.
    class window_trend_tracker;
        localparam int unsigned RING_DEPTH = MAX_WINDOW_DEF;

        logic        [CNT_W-1:0]    length_setting;
        logic signed [SAMPLE_W-1:0] ring [RING_DEPTH];
        int unsigned                held_now;
        int unsigned                oldest_idx;
        longint                     window_sum;
        longint                     weighted_sum;
        trend_result_t              expected_trends [$];
        int unsigned                mismatch_count;
        int unsigned                results_checked;

        function new();
            length_setting  = WL_RESET;
            mismatch_count  = 0;
            results_checked = 0;
            clear_history();
        endfunction

        function void clear_history();
            foreach (ring[i]) ring[i] = '0;
            held_now     = 0;
            oldest_idx   = 0;
            window_sum   = 0;
            weighted_sum = 0;
        endfunction

        // A write of the length register always empties the window.
        function void write_length(logic [CNT_W-1:0] value);
            length_setting = value;
            clear_history();
        endfunction

        function logic signed [SAMPLE_W-1:0] saturate(longint v);
            if (v > 64'sd2147483647) return SAT_MAX;
            if (v < -64'sd2147483648) return SAT_MIN;
            return v[SAMPLE_W-1:0];
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] y);
            int unsigned   eff;
            int unsigned   slot;
            longint        n;
            longint        sx;
            longint        den;
            longint        num;
            trend_result_t r;
            eff = length_setting;
            if (eff < 1) eff = 1;
            if (eff > RING_DEPTH) eff = RING_DEPTH;
            if (held_now >= eff) begin
                // Full window: the oldest sample leaves and every index
                // drops by one, which takes one window sum off the weights.
                slot = oldest_idx;
                if (slot >= eff) slot = 0;
                window_sum   -= longint'(ring[slot]);
                weighted_sum -= window_sum;
                ring[slot] = y;
                slot++;
                if (slot >= eff) slot = 0;
                oldest_idx = slot;
                held_now   = eff;
            end else begin
                ring[held_now] = y;
                held_now++;
            end
            n = held_now;
            weighted_sum += (n - 1) * longint'(y);
            window_sum   += longint'(y);
            r.held  = held_now[CNT_W-1:0];
            r.mean  = saturate(window_sum / n);
            r.slope = '0;
            if (n >= 2) begin
                sx  = n * (n - 1) / 2;
                den = n * n * (n * n - 1) / 12;
                num = n * weighted_sum - sx * window_sum;
                r.slope = saturate(num / den);
            end
            expected_trends.push_back(r);
        endfunction

        function void compare_field(string label, longint want, longint got);
            if (want != got) begin
                mismatch_count++;
                $display("%0t: %s expected %0d, actual %0d", $time, label, want, got);
            end
        endfunction

        function void compare_result(logic [CNT_W-1:0] held, logic signed [SAMPLE_W-1:0] mean,
                                     logic signed [SAMPLE_W-1:0] slope);
            trend_result_t w;
            results_checked++;
            if (expected_trends.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with no sample pending, expected none, actual %0d/%0d/%0d",
                         $time, held, mean, slope);
                return;
            end
            w = expected_trends.pop_front();
            compare_field("samples_held", longint'(w.held), longint'(held));
            compare_field("window_mean", longint'(w.mean), longint'(mean));
            compare_field("trend_slope", longint'(w.slope), longint'(slope));
        endfunction

        function int pending();
            return expected_trends.size();
        endfunction
    endclass

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic        [CNT_W-1:0]    cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_fitness_sample;
    logic                       m_valid;
    logic                       m_ready;
    logic        [CNT_W-1:0]    m_samples_held;
    logic signed [SAMPLE_W-1:0] m_window_mean;
    logic signed [SAMPLE_W-1:0] m_trend_slope;

    window_trend_tracker tracker = new();

    // When set, neither side inserts random idle gaps (the one long receiver stall apart).
    bit          no_gaps;
    int unsigned samples_sent;
    int unsigned cycle_count;

    window_average_and_trend_core DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_fitness_sample (s_fitness_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_samples_held   (m_samples_held),
        .m_window_mean    (m_window_mean),
        .m_trend_slope    (m_trend_slope)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle length for either side: mostly none or short, now and then a long one.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Sample shapes: 0 is uniform over all 32 bits, 1 is small values near
    // zero, 2 is a noisy ramp so that the slope means something, and 3 picks
    // among the extremes of the signed range and the values -1, 0 and 1.
    function automatic logic signed [SAMPLE_W-1:0] make_sample(int unsigned shape, int idx,
                                                               int base, int step);
        case (shape)
            1: return $urandom_range(0, 131071) - 65536;
            2: return base + idx * step + ($urandom_range(0, 255) - 128);
            3: begin
                case ($urandom_range(0, 6))
                    0: return SAT_MAX;
                    1: return SAT_MIN;
                    2: return SAT_MAX - 1;
                    3: return SAT_MIN + 1;
                    4: return -1;
                    5: return 1;
                    default: return 0;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Offers one sample after a random gap and returns once the transaction
    // has been taken. Valid is left high, so a following sample with no gap
    // keeps it high without lowering it in between.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_fitness_sample <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_sample(value);
        samples_sent++;
    endtask

    // The length register is only written with the block idle: no sample is
    // offered and every predicted result has come back. Since each sample
    // gives exactly one result, nothing is left in flight at that point.
    task automatic write_window_length(input logic [CNT_W-1:0] value);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        tracker.write_length(value);
    endtask

    // Result side. Each accepted result transaction is checked on the edge
    // that takes it. Once, after the first hundred results, the receiver
    // holds off for a long stretch while the sender keeps offering, so the
    // block fills up and has to stall its input.
    initial begin
        int unsigned stall_left;
        bit          pressure_done;
        stall_left    = 0;
        pressure_done = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.compare_result(m_samples_held, m_window_mean, m_trend_slope);
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!pressure_done && tracker.results_checked >= 100) begin
                pressure_done = 1'b1;
                stall_left    = 500;
                m_ready <= 1'b0;
            end else begin
                stall_left = idle_cycles();
                m_ready <= (stall_left == 0);
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int unsigned      phase;
        int unsigned      eff;
        int unsigned      count;
        int unsigned      shape;
        int               base;
        int               step;
        logic [CNT_W-1:0] len;

        aresetn          <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= '0;
        s_valid          <= 1'b0;
        s_fitness_sample <= '0;
        no_gaps      = 1'b0;
        samples_sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset length of 50: the extremes of the sample range and the
        // values around zero, with the slope zero on the very first sample.
        send_sample(SAT_MAX);
        send_sample(SAT_MIN);
        send_sample(0);
        send_sample(-1);
        send_sample(1);
        send_sample(32'sh0001_0000);

        // A length of zero behaves as a window of one.
        write_window_length(7'd0);
        send_sample(SAT_MIN);
        send_sample(SAT_MAX);
        send_sample(3);

        // With two samples the denominator is one, so jumps between the most
        // negative and the most positive value drive the slope past both
        // ends of the range and it has to saturate.
        write_window_length(7'd2);
        send_sample(SAT_MIN);
        send_sample(SAT_MAX);
        send_sample(SAT_MIN);
        send_sample(SAT_MAX);
        send_sample(0);

        // Random phases. The first few pin the extreme length settings:
        // one, the full ring, the largest register value (clamped to the
        // ring), zero and just above the ring, then two and the reset length.
        // After that most windows are short so that they fill and wrap often.
        phase = 0;
        while (samples_sent < SAMPLE_COUNT) begin
            case (phase)
                0: len = 7'd1;
                1: len = 7'd64;
                2: len = 7'd127;
                3: len = 7'd0;
                4: len = 7'd65;
                5: len = 7'd2;
                6: len = WL_RESET;
                default: begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: len = $urandom_range(1, 8);
                        5, 6, 7:       len = $urandom_range(9, 64);
                        default:       len = $urandom_range(0, 127);
                    endcase
                end
            endcase
            write_window_length(len);

            eff = (len == 0) ? 1 : (len > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : len;
            count = eff + $urandom_range(4, 40);
            if (count > SAMPLE_COUNT - samples_sent) count = SAMPLE_COUNT - samples_sent;
            shape   = $urandom_range(0, 3);
            no_gaps = ($urandom_range(0, 4) == 0);
            base    = $urandom;
            step    = int'($urandom) >>> $urandom_range(4, 30);

            for (int i = 0; i < count; i++) begin
                // A tenth of the samples are plain noise whatever the shape.
                if ($urandom_range(0, 9) == 0)
                    send_sample($urandom);
                else
                    send_sample(make_sample(shape, i, base, step));
            end
            phase++;
        end

        // Drain every outstanding result, then keep watching the result side
        // for anything unexpected to show up.
        s_valid <= 1'b0;
        no_gaps = 1'b1;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/wat_pkg.sv
rtl/wat_ram.sv
rtl/wat_div.sv
rtl/window_average_and_trend_core.sv
tb/tb_window_average_and_trend_core.sv
